/* src/cfe_pkg.sv */
package cfe_pkg;

  localparam int IN_BITS       = 32;
  localparam int TERM_BITS     = 32;
  localparam int EXT_BITS      = 64;
  localparam int MAX_TERMS     = 48;
  localparam int WORD_BITS_DEF = 32;

endpackage

/* src/cfe_div.sv */
module cfe_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem
);

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] den_r;
  logic [WORD_BITS-1:0] quo_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;

  assign trial = {rem_r, quo_r[WORD_BITS-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      den_r <= den;
      quo_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[WORD_BITS]) begin
        rem_r <= diff[WORD_BITS-1:0];
        quo_r <= {quo_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_r <= trial[WORD_BITS-1:0];
        quo_r <= {quo_r[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* src/continued_fraction_expansion_unit.sv */
// Continued fraction expansion of one unsigned fraction per input beat.
// The input channel (in_valid, in_ready) takes a numerator and a
// denominator. The result channel (out_valid, out_ready) delivers one beat
// per continued fraction term, with out_last set on the final term.
// A zero denominator gives a single beat with term 0, out_last and
// out_div_error set.
// Each term comes from a shift-subtract divider that retires one quotient
// bit per cycle; a new division starts only when the previous term moves
// into the output register. An item gives at most MAX_TERMS (48) terms;
// out_last is set on the term that reaches that limit.
// in_ready is high only while no item is in progress; the final term may
// still wait in the output register while the next item is accepted.
// If the receiver stalls, the finished term waits in the output register
// and the next division result waits in the divider until the slot frees.
// Reset clears the sequencer and the output valid; no other state is kept.
module continued_fraction_expansion_unit #(
  parameter int WORD_BITS = cfe_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cfe_pkg::IN_BITS-1:0]   in_numerator,
  input  logic [cfe_pkg::IN_BITS-1:0]   in_denominator,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cfe_pkg::TERM_BITS-1:0] out_term,
  output logic                          out_last,
  output logic                          out_div_error
);

  import cfe_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_TERMS);
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(MAX_TERMS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WORD_BITS-1:0]   b_r, b_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TERM_BITS-1:0]   term_r, term_nxt;
  logic                   last_r, last_nxt;
  logic                   derr_r, derr_nxt;

  logic                   div_start;
  logic [WORD_BITS-1:0]   div_num;
  logic [WORD_BITS-1:0]   div_den;
  logic                   div_busy;
  logic                   div_done;
  logic [WORD_BITS-1:0]   div_quo;
  logic [WORD_BITS-1:0]   div_rem;

  logic [EXT_BITS-1:0]    num_ext;
  logic [EXT_BITS-1:0]    den_ext;
  logic [EXT_BITS-1:0]    quo_ext;
  logic [WORD_BITS-1:0]   in_num_w;
  logic [WORD_BITS-1:0]   in_den_w;
  logic                   slot_free;
  logic                   fin;

  assign num_ext   = EXT_BITS'(in_numerator);
  assign den_ext   = EXT_BITS'(in_denominator);
  assign quo_ext   = EXT_BITS'(div_quo);
  assign in_num_w  = num_ext[WORD_BITS-1:0];
  assign in_den_w  = den_ext[WORD_BITS-1:0];
  assign slot_free = !out_valid_r || out_ready;
  assign fin       = (div_rem == '0) || (cnt_r == LAST_CNT);

  cfe_div #(
    .WORD_BITS(WORD_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    term_nxt      = term_r;
    last_nxt      = last_r;
    derr_nxt      = derr_r;
    div_start     = 1'b0;
    div_num       = in_num_w;
    div_den       = in_den_w;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt = '0;
          b_nxt   = in_den_w;
          if (in_den_w == '0) begin
            err_nxt   = 1'b1;
            state_nxt = ST_HOLD;
          end else begin
            err_nxt   = 1'b0;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          derr_nxt      = err_r;
          if (err_r) begin
            term_nxt  = '0;
            last_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            term_nxt = quo_ext[TERM_BITS-1:0];
            last_nxt = fin;
            if (fin) begin
              state_nxt = ST_IDLE;
            end else begin
              div_start = 1'b1;
              div_num   = b_r;
              div_den   = div_rem;
              b_nxt     = div_rem;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    term_r <= term_nxt;
    last_r <= last_nxt;
    derr_r <= derr_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_term      = term_r;
  assign out_last      = last_r;
  assign out_div_error = derr_r;

  a_err_beat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && derr_r |-> last_r && (term_r == '0))
    else $error("error beat without last or with nonzero term");

  a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("input ready while divider busy");

  a_zero_den : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_den_w == '0) |=> err_r && (state_r == ST_HOLD))
    else $error("zero denominator not flagged");

  a_start_free : assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy && (div_den != '0))
    else $error("division started while busy or by zero");

endmodule
